FILE: design/assert_macros.svh
// Assertion helpers used by sensor_frame_receiver_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int FRAME_LEN = 17;
   localparam int STORE_LEN = FRAME_LEN - 1;

   localparam logic [7:0] HEADER_BYTE = 8'h3C;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;

   localparam logic [4:0]  LAST_BYTE_COUNT  = 5'(FRAME_LEN);
   localparam logic [14:0] CENTI_SCALE      = 15'd100;
   localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd100;

   // Register index, taken from the word address
   localparam logic REG_IDLE_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_TIMEOUT  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] co2;
      logic [15:0] formaldehyde;
      logic [15:0] tvoc;
      logic [15:0] pm2_5;
      logic [15:0] pm10;
      logic [14:0] temperature_centi;
      logic [14:0] humidity_centi;
   } readings_type;

endpackage

FILE: design/sensor_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser: mode, tdata: rx_byte
// rsp_      out        rsp_tvalid/rsp_tready  tuser: status, tdata: readings, changed
// csr_      in         APB, pready always 1   idle_timeout at byte address 0
//
// One item per clock unless stalled: an item sits in the input register, is worked
// against the frame state while there and leaves its result in the output register.
// Between acceptance and result valid lie the input register and the output register.
// Reset is synchronous, active high; the reading store needs no clearing.
// The input register holds only while an item with a result meets a full,
// stalled output register; items with no result never wait on rsp_tready.

`include "assert_macros.svh"

module sensor_frame_receiver_unit (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tuser,   // [0] mode

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] co2, [31:16] formaldehyde, [47:32] tvoc, [63:48] pm2_5,
   // [79:64] pm10, [94:80] temperature_centi, [109:95] humidity_centi,
   // [110] changed, [111] zero
   output logic [111:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // [1:0] status

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // configuration
   logic [15:0] idle_timeout_ff;
   logic        csr_write;

   // input register
   logic        s1_valid_ff;
   logic        s1_mode_ff;
   logic [7:0]  s1_byte_ff;

   // frame state
   logic        in_frame_ff,    in_frame_in;
   logic [4:0]  byte_count_ff,  byte_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [15:0] idle_count_ff,  idle_count_in;
   logic [7:0]  frame_store_ff [sfr_pkg::STORE_LEN];
   logic        store_we;
   logic [3:0]  store_idx;

   sfr_pkg::readings_type last_ff, last_in;
   sfr_pkg::readings_type frame_rd;

   // result
   logic                  emit;
   sfr_pkg::status_type   status;
   logic                  changed;
   logic                  rsp_valid_ff;
   sfr_pkg::status_type   rsp_status_ff;
   sfr_pkg::readings_type rsp_rd_ff;
   logic                  rsp_changed_ff;

   logic        is_idle;
   logic [16:0] next_idle;
   logic        stall;
   logic        consume;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == sfr_pkg::REG_IDLE_TIMEOUT) ?
                       {16'd0, idle_timeout_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= sfr_pkg::IDLE_TIMEOUT_RST;
      end else if (csr_write && csr_paddr[2] == sfr_pkg::REG_IDLE_TIMEOUT) begin
         idle_timeout_ff <= csr_pwdata[15:0];
      end
   end

   // ---------------- handshake ----------------
   assign stall      = s1_valid_ff && emit && rsp_valid_ff && !rsp_tready;
   assign consume    = s1_valid_ff && !stall;
   assign req_tready = !s1_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_mode_ff <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
   end

   // ---------------- frame decode ----------------
   assign frame_rd.co2               = {frame_store_ff[2],  frame_store_ff[3]};
   assign frame_rd.formaldehyde      = {frame_store_ff[4],  frame_store_ff[5]};
   assign frame_rd.tvoc              = {frame_store_ff[6],  frame_store_ff[7]};
   assign frame_rd.pm2_5             = {frame_store_ff[8],  frame_store_ff[9]};
   assign frame_rd.pm10              = {frame_store_ff[10], frame_store_ff[11]};
   assign frame_rd.temperature_centi = {7'd0, frame_store_ff[12]} * sfr_pkg::CENTI_SCALE
                                       + {7'd0, frame_store_ff[13]};
   assign frame_rd.humidity_centi    = {7'd0, frame_store_ff[14]} * sfr_pkg::CENTI_SCALE
                                       + {7'd0, frame_store_ff[15]};

   assign is_idle = s1_mode_ff || (s1_byte_ff == sfr_pkg::IDLE_BYTE);

   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      idle_count_in  = idle_count_ff;
      last_in        = last_ff;
      store_we       = 1'b0;
      store_idx      = byte_count_ff[3:0];
      next_idle      = {1'b0, idle_count_ff} + 17'd1;
      emit           = 1'b0;
      status         = sfr_pkg::STATUS_OK;
      changed        = 1'b0;

      if (!in_frame_ff) begin
         // hunt for the header, drop everything else
         if (!is_idle && s1_byte_ff == sfr_pkg::HEADER_BYTE) begin
            in_frame_in    = 1'b1;
            store_we       = 1'b1;
            store_idx      = 4'd0;
            byte_count_in  = 5'd1;
            running_sum_in = s1_byte_ff;
            idle_count_in  = 16'd0;
         end
      end else begin
         if (!is_idle) begin
            if (!byte_count_ff[4]) begin
               store_we       = 1'b1;
               running_sum_in = running_sum_ff + s1_byte_ff;
            end
            byte_count_in = byte_count_ff + 5'd1;
            next_idle     = 17'd1;
         end

         if (next_idle > {1'b0, idle_timeout_ff}) begin
            emit   = 1'b1;
            status = sfr_pkg::STATUS_TIMEOUT;
         end else begin
            idle_count_in = next_idle[15:0];
            if (!is_idle && byte_count_in == sfr_pkg::LAST_BYTE_COUNT) begin
               emit = 1'b1;
               if (running_sum_in != s1_byte_ff) begin
                  status = sfr_pkg::STATUS_CHECKSUM;
               end else begin
                  changed = (frame_rd != last_ff);
                  if (changed) begin
                     last_in = frame_rd;
                  end
               end
            end
         end

         // close the frame on any result
         if (emit) begin
            in_frame_in    = 1'b0;
            byte_count_in  = 5'd0;
            running_sum_in = 8'd0;
            idle_count_in  = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= 5'd0;
         running_sum_ff <= 8'd0;
         idle_count_ff  <= 16'd0;
         last_ff        <= '0;
      end else if (consume) begin
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         idle_count_ff  <= idle_count_in;
         last_ff        <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && store_we) begin
         frame_store_ff[store_idx] <= s1_byte_ff;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (consume && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && emit) begin
         rsp_status_ff  <= status;
         rsp_rd_ff      <= (status == sfr_pkg::STATUS_OK) ? frame_rd : '0;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_changed_ff,
                        rsp_rd_ff.humidity_centi, rsp_rd_ff.temperature_centi,
                        rsp_rd_ff.pm10, rsp_rd_ff.pm2_5, rsp_rd_ff.tvoc,
                        rsp_rd_ff.formaldehyde, rsp_rd_ff.co2};

   // ---------------- assertions ----------------
   `ASSERT_SAME_CYCLE(a_count_in_frame, clock, reset, in_frame_ff,
      byte_count_ff >= 5'd1 && byte_count_ff <= 5'(sfr_pkg::STORE_LEN),
      "byte count out of range inside a frame")
   `ASSERT_SAME_CYCLE(a_clear_outside_frame, clock, reset, !in_frame_ff,
      byte_count_ff == 5'd0 && idle_count_ff == 16'd0 && running_sum_ff == 8'd0,
      "frame counters not cleared outside a frame")
   `ASSERT_NEXT_CYCLE(a_result_closes_frame, clock, reset, consume && emit,
      !in_frame_ff && rsp_valid_ff, "result did not close the frame")
   `ASSERT_SAME_CYCLE(a_error_has_no_change, clock, reset,
      rsp_valid_ff && rsp_status_ff != sfr_pkg::STATUS_OK,
      !rsp_changed_ff && rsp_rd_ff == '0, "error result carries readings")

endmodule
